// ===== rtl/sgql_pkg.sv =====
package sgql_pkg;

    localparam int MAX_X        = 16;
    localparam int MAX_Y        = 16;
    localparam int MAX_Z        = 16;
    localparam int MAX_CHANNELS = 16;

    localparam int SZ_W     = 5;
    localparam int IDX_W    = 4;
    localparam int ADDR_W   = 16;
    localparam int SAMPLE_W = 24;
    localparam int POS_W    = 24;
    localparam int LAM_W    = 20;
    localparam int SCALE_W  = 32;
    localparam int WGT_W    = 16;
    localparam int DIV_W    = 12;
    localparam int CFG_W    = 32;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] WRAP_REPEAT = 2'd0;
    localparam logic [1:0] WRAP_MIRROR = 2'd1;
    localparam logic [1:0] WRAP_CLAMP  = 2'd2;

    typedef enum logic [2:0] {
        CFG_SIZE_X,
        CFG_SIZE_Y,
        CFG_SIZE_Z,
        CFG_CHANNEL_COUNT,
        CFG_WRAP_MODE,
        CFG_BAND_LOW,
        CFG_BAND_HIGH,
        CFG_SPECTRAL_SCALE
    } t_cfg_idx;

    typedef struct packed {
        logic                       cmd;
        logic [ADDR_W-1:0]          write_address;
        logic [SAMPLE_W-1:0]        write_sample;
        logic signed [POS_W-1:0]    pos_x;
        logic signed [POS_W-1:0]    pos_y;
        logic signed [POS_W-1:0]    pos_z;
        logic [LAM_W-1:0]           wavelength;
    } t_in_item;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_out;
        logic                out_of_band;
    } t_out_item;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [SZ_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [SZ_W-1:0]  rem;
    } t_div_rsp;

    function automatic logic [SZ_W-1:0] eff_size(input logic [SZ_W-1:0] v,
                                                 input logic [SZ_W-1:0] maxv);
        logic [SZ_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = SZ_W'(1);
        end else if (v > maxv) begin
            res = maxv;
        end
        return res;
    endfunction

endpackage

// ===== rtl/sgql_store.sv =====
module sgql_store (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [sgql_pkg::ADDR_W-1:0]        i_waddr,
    input  logic [sgql_pkg::SAMPLE_W-1:0]      i_wdata,
    input  logic                               i_re,
    input  logic [sgql_pkg::ADDR_W-1:0]        i_raddr,
    output logic [sgql_pkg::SAMPLE_W-1:0]      o_rdata
);

    logic [sgql_pkg::SAMPLE_W-1:0] r_mem [2**sgql_pkg::ADDR_W];
    logic [sgql_pkg::SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sgql_div.sv =====
module sgql_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sgql_pkg::t_div_req  i_req,
    output sgql_pkg::t_div_rsp  o_rsp
);

    localparam int CNT_W = $clog2(sgql_pkg::DIV_W);

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [sgql_pkg::DIV_W-1:0]    r_dvd;
    logic [sgql_pkg::DIV_W-1:0]    r_quo;
    logic [sgql_pkg::SZ_W-1:0]     r_rem;
    logic [sgql_pkg::SZ_W-1:0]     r_d;
    logic [sgql_pkg::SZ_W:0]       trial;
    logic                          take;
    logic [sgql_pkg::SZ_W-1:0]     n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[sgql_pkg::DIV_W-1]};
        take  = trial >= {1'b0, r_d};
        n_rem = take ? sgql_pkg::SZ_W'(trial - {1'b0, r_d})
                     : trial[sgql_pkg::SZ_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= i_req.dividend;
                r_d    <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[sgql_pkg::DIV_W-2:0], take};
                r_dvd <= {r_dvd[sgql_pkg::DIV_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(sgql_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

// ===== rtl/spectral_grid_quadrilinear_lookup_core.sv =====
// Quadrilinear lookup into a three-dimensional grid of spectra.
// The input channel carries one transaction per item. A write transaction
// stores one 24-bit sample and is done in the cycle it is accepted. A query
// transaction yields exactly one transaction on the output channel.
// A query in band places the coordinates on the three axes, does one spectral
// multiply, six index wraps on the shared 12-step divider and the address
// arithmetic, reads its samples from the single store port, does 15 blends on
// the shared multiplier and loads the output register. A query out of band
// goes through the finish state to the output register and returns zero with
// out_of_band set. The input is ready only while no query is in progress, and
// is ready again when its result appears.
// The configuration port writes one register per cycle with no wait; the user
// must write it only while the block is idle, which the block does not enforce.
// Reset restores the register defaults and empties the output register; the
// sample store is not cleared and must be written before it is read.
// When the receiver stalls, the finished result waits in the output register
// while writes are still accepted; a later query holds at its end until the
// output register is free.
module spectral_grid_quadrilinear_lookup_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  sgql_pkg::t_in_item                  i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output sgql_pkg::t_out_item                 o_out,
    input  logic                                i_cfg_we,
    input  logic [2:0]                          i_cfg_index,
    input  logic [sgql_pkg::CFG_W-1:0]          i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_SPEC,
        S_WRAP_GO,
        S_WRAP_WAIT,
        S_SCALE,
        S_FETCH,
        S_BLEND,
        S_FINISH
    } t_state;

    localparam int SZ  = sgql_pkg::SZ_W;
    localparam int IW  = sgql_pkg::IDX_W;
    localparam int AW  = sgql_pkg::ADDR_W;
    localparam int DW  = sgql_pkg::SAMPLE_W;
    localparam int PW  = sgql_pkg::POS_W;
    localparam int LW  = sgql_pkg::LAM_W;
    localparam int WW  = sgql_pkg::WGT_W;
    localparam int TW  = PW + SZ + 1;
    localparam int BW  = TW - WW;
    localparam int SPW = LW + sgql_pkg::SCALE_W;
    localparam int MW  = WW + 1 + DW;

    t_state                       r_state;
    logic [SZ-1:0]                r_size_x, r_size_y, r_size_z, r_chans;
    logic [1:0]                   r_wrap;
    logic [LW-1:0]                r_band_low, r_band_high;
    logic [sgql_pkg::SCALE_W-1:0] r_scale;

    sgql_pkg::t_in_item           r_item;
    logic [4:0]                   r_cnt;
    logic                         r_phase;
    logic signed [BW-1:0]         r_base [3];
    logic [WW-1:0]                r_w [4];
    logic [IW-1:0]                r_idx [6];
    logic [IW-1:0]                r_ci [2];
    logic [SPW-1:0]               r_spec;
    logic [2*SZ-1:0]              r_sy;
    logic [AW-1:0]                r_sz;
    logic [IW+SZ-1:0]             r_ax [2];
    logic [IW+2*SZ-1:0]           r_ay [2];
    logic [AW-1:0]                r_az [2];
    logic [DW-1:0]                r_q [16];
    logic [4:0]                   r_qcnt;
    logic [MW-1:0]                r_acc;
    logic                         r_rd_v;
    logic [3:0]                   r_rd_k;
    logic [DW-1:0]                r_res;
    logic                         r_oob;
    logic                         r_o_valid;
    sgql_pkg::t_out_item          r_out;

    logic [SZ-1:0]                eff_n [3];
    logic [SZ-1:0]                eff_ch;
    logic [1:0]                   axis;
    logic signed [PW-1:0]         pos_sel;
    logic signed [TW-1:0]         t_val;
    logic signed [BW-1:0]         wv;
    logic [BW-1:0]                mag;
    logic [SZ-1:0]                wn;
    logic                         wneg;
    logic [SZ-1:0]                wmod;
    logic [IW-1:0]                widx;
    sgql_pkg::t_div_req           div_req;
    sgql_pkg::t_div_rsp           div_rsp;
    logic [LW-1:0]                wi;
    logic [LW:0]                  wi1;
    logic [SZ-1:0]                nch_m1;
    logic [LW-1:0]                lam_off;
    logic [AW-1:0]                rd_addr;
    logic                         rd_en;
    logic                         wr_en;
    logic [DW-1:0]                rd_data;
    logic [1:0]                   lvl;
    logic [WW-1:0]                wsel;
    logic [WW:0]                  mult_a;
    logic [DW-1:0]                mult_b;
    logic [MW-1:0]                prod;
    logic [MW:0]                  bsum;
    logic [DW-1:0]                bres;
    logic                         oob;
    logic [3:0]                   qpos;
    logic                         out_load;

    always_comb begin
        eff_n[0] = sgql_pkg::eff_size(r_size_x, SZ'(sgql_pkg::MAX_X));
        eff_n[1] = sgql_pkg::eff_size(r_size_y, SZ'(sgql_pkg::MAX_Y));
        eff_n[2] = sgql_pkg::eff_size(r_size_z, SZ'(sgql_pkg::MAX_Z));
        eff_ch   = sgql_pkg::eff_size(r_chans, SZ'(sgql_pkg::MAX_CHANNELS));
    end

    always_comb begin
        axis = (r_state == S_PREP) ? r_cnt[1:0] : r_cnt[2:1];
        case (axis)
            2'd0:    pos_sel = r_item.pos_x;
            2'd1:    pos_sel = r_item.pos_y;
            default: pos_sel = r_item.pos_z;
        endcase
        t_val = TW'(pos_sel) * $signed(TW'({1'b0, eff_n[axis]})) - TW'(32768);
    end

    always_comb begin
        wv   = r_base[axis] + BW'(r_cnt[0]);
        wneg = wv[BW-1];
        mag  = wneg ? BW'(-wv) : BW'(wv);
        wn   = eff_n[axis];
        div_req.start    = (r_state == S_WRAP_GO);
        div_req.dividend = mag[sgql_pkg::DIV_W-1:0];
        div_req.divisor  = wn;
        wmod = div_rsp.rem;
        if (wneg && div_rsp.rem != '0) begin
            wmod = wn - div_rsp.rem;
        end
        if (r_wrap == sgql_pkg::WRAP_MIRROR && (!div_rsp.quot[0]) == wneg) begin
            wmod = wn - SZ'(1) - wmod;
        end
        case (r_wrap)
            sgql_pkg::WRAP_REPEAT, sgql_pkg::WRAP_MIRROR: begin
                widx = wmod[IW-1:0];
            end
            default: begin
                if (wneg) begin
                    widx = '0;
                end else if (wv > $signed({{(BW-SZ){1'b0}}, wn - SZ'(1)})) begin
                    widx = IW'(wn - SZ'(1));
                end else begin
                    widx = wv[IW-1:0];
                end
            end
        endcase
    end

    sgql_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        wi      = r_spec[SPW-1:sgql_pkg::SCALE_W];
        wi1     = {1'b0, wi} + (LW+1)'(1);
        nch_m1  = eff_ch - SZ'(1);
        lam_off = r_item.wavelength - r_band_low;
    end

    always_comb begin
        rd_en   = (r_state == S_FETCH) && !r_cnt[4];
        rd_addr = r_az[r_cnt[2]] + AW'(r_ay[r_cnt[1]]) + AW'(r_ax[r_cnt[0]])
                + AW'(r_ci[r_cnt[3]]);
        wr_en   = (r_state == S_IDLE) && i_in_valid && (i_in.cmd == sgql_pkg::CMD_WRITE);
    end

    sgql_store u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (i_in.write_address),
        .i_wdata (i_in.write_sample),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        if (r_cnt < 5'd8) begin
            lvl = 2'd0;
        end else if (r_cnt < 5'd12) begin
            lvl = 2'd1;
        end else if (r_cnt < 5'd14) begin
            lvl = 2'd2;
        end else begin
            lvl = 2'd3;
        end
        wsel     = r_w[lvl];
        mult_a   = r_phase ? {1'b0, wsel} : ((WW+1)'(1) << WW) - {1'b0, wsel};
        mult_b   = r_phase ? r_q[1] : r_q[0];
        prod     = MW'(mult_a) * MW'(mult_b);
        bsum     = {1'b0, r_acc} + {1'b0, prod};
        bres     = bsum[WW+DW-1:WW];
        qpos     = 4'(r_qcnt - 5'd2);
        oob      = (i_in.wavelength < r_band_low) || (i_in.wavelength > r_band_high);
        out_load = (r_state == S_FINISH) && (!r_o_valid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_size_x    <= SZ'(16);
            r_size_y    <= SZ'(16);
            r_size_z    <= SZ'(16);
            r_chans     <= SZ'(16);
            r_wrap      <= sgql_pkg::WRAP_CLAMP;
            r_band_low  <= '0;
            r_band_high <= '1;
            r_scale     <= '0;
            r_o_valid   <= 1'b0;
            r_rd_v      <= 1'b0;
            r_cnt       <= '0;
            r_phase     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (sgql_pkg::t_cfg_idx'(i_cfg_index))
                    sgql_pkg::CFG_SIZE_X:         r_size_x    <= i_cfg_data[SZ-1:0];
                    sgql_pkg::CFG_SIZE_Y:         r_size_y    <= i_cfg_data[SZ-1:0];
                    sgql_pkg::CFG_SIZE_Z:         r_size_z    <= i_cfg_data[SZ-1:0];
                    sgql_pkg::CFG_CHANNEL_COUNT:  r_chans     <= i_cfg_data[SZ-1:0];
                    sgql_pkg::CFG_WRAP_MODE:      r_wrap      <= i_cfg_data[1:0];
                    sgql_pkg::CFG_BAND_LOW:       r_band_low  <= i_cfg_data[LW-1:0];
                    sgql_pkg::CFG_BAND_HIGH:      r_band_high <= i_cfg_data[LW-1:0];
                    sgql_pkg::CFG_SPECTRAL_SCALE: r_scale     <= i_cfg_data;
                    default: ;
                endcase
            end

            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            r_rd_v <= rd_en;
            r_rd_k <= r_cnt[3:0];

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && i_in.cmd == sgql_pkg::CMD_QUERY) begin
                        r_item <= i_in;
                        r_oob  <= oob;
                        r_cnt  <= '0;
                        r_state <= oob ? S_FINISH : S_PREP;
                    end
                end
                S_PREP: begin
                    r_base[axis] <= t_val[TW-1:WW];
                    r_w[axis]    <= t_val[WW-1:0];
                    if (r_cnt == 5'd2) begin
                        r_state <= S_SPEC;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_SPEC: begin
                    r_spec  <= SPW'(lam_off) * SPW'(r_scale);
                    r_cnt   <= '0;
                    r_state <= S_WRAP_GO;
                end
                S_WRAP_GO: begin
                    r_state <= S_WRAP_WAIT;
                end
                S_WRAP_WAIT: begin
                    if (div_rsp.done) begin
                        r_idx[r_cnt[2:0]] <= widx;
                        if (r_cnt == 5'd5) begin
                            r_cnt   <= '0;
                            r_state <= S_SCALE;
                        end else begin
                            r_cnt   <= r_cnt + 5'd1;
                            r_state <= S_WRAP_GO;
                        end
                    end
                end
                S_SCALE: begin
                    r_w[3] <= r_spec[sgql_pkg::SCALE_W-1:sgql_pkg::SCALE_W-WW];
                    case (r_cnt[1:0])
                        2'd0: begin
                            r_sy    <= (2*SZ)'(eff_n[0]) * (2*SZ)'(eff_ch);
                            r_ax[0] <= (IW+SZ)'(r_idx[0]) * (IW+SZ)'(eff_ch);
                            r_ax[1] <= (IW+SZ)'(r_idx[1]) * (IW+SZ)'(eff_ch);
                            r_ci[0] <= (wi > LW'(nch_m1)) ? nch_m1[IW-1:0] : wi[IW-1:0];
                            r_ci[1] <= (wi1 > (LW+1)'(nch_m1)) ? nch_m1[IW-1:0]
                                                               : wi1[IW-1:0];
                        end
                        2'd1: begin
                            r_sz    <= AW'(eff_n[1]) * AW'(r_sy);
                            r_ay[0] <= (IW+2*SZ)'(r_idx[2]) * (IW+2*SZ)'(r_sy);
                            r_ay[1] <= (IW+2*SZ)'(r_idx[3]) * (IW+2*SZ)'(r_sy);
                        end
                        default: begin
                            r_az[0] <= AW'(r_idx[4]) * r_sz;
                            r_az[1] <= AW'(r_idx[5]) * r_sz;
                        end
                    endcase
                    if (r_cnt == 5'd2) begin
                        r_cnt   <= '0;
                        r_state <= S_FETCH;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_FETCH: begin
                    if (r_rd_v) begin
                        r_q[r_rd_k] <= rd_data;
                    end
                    if (r_cnt[4]) begin
                        r_cnt   <= '0;
                        r_phase <= 1'b0;
                        r_qcnt  <= 5'd16;
                        r_state <= S_BLEND;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_BLEND: begin
                    if (!r_phase) begin
                        r_acc   <= prod;
                        r_phase <= 1'b1;
                    end else begin
                        r_phase <= 1'b0;
                        for (int i = 0; i < 14; i++) begin
                            r_q[i] <= (4'(i) == qpos) ? bres : r_q[i+2];
                        end
                        if (qpos == 4'd14) begin
                            r_q[14] <= bres;
                        end
                        r_qcnt    <= r_qcnt - 5'd1;
                        if (r_cnt == 5'd14) begin
                            r_res   <= bres;
                            r_state <= S_FINISH;
                        end else begin
                            r_cnt <= r_cnt + 5'd1;
                        end
                    end
                end
                S_FINISH: begin
                    if (out_load) begin
                        r_out.sample_out  <= r_oob ? '0 : r_res;
                        r_out.out_of_band <= r_oob;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_o_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/sgql_chk.sv =====
module sgql_chk (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   o_in_ready,
    input  sgql_pkg::t_in_item     i_in,
    input  logic                   o_out_valid,
    input  logic                   i_out_ready,
    input  sgql_pkg::t_out_item    o_out
);

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in.cmd == sgql_pkg::CMD_QUERY) |=> !o_in_ready)
        else $error("Input still ready after a query transaction.");

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in.cmd == sgql_pkg::CMD_WRITE) |=> o_in_ready)
        else $error("A write transaction left the block busy.");

    a_oob_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.out_of_band) |-> (o_out.sample_out == '0))
        else $error("Out of band result carries a nonzero sample.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("Stalled output transaction changed.");

endmodule

bind spectral_grid_quadrilinear_lookup_core sgql_chk u_sgql_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

// ===== tb/spectral_grid_quadrilinear_lookup_core_test.sv =====
module spectral_grid_quadrilinear_lookup_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    sgql_pkg::t_in_item            i_in;
    logic                          o_out_valid;
    logic                          i_out_ready;
    sgql_pkg::t_out_item           o_out;
    logic                          i_cfg_we;
    logic [2:0]                    i_cfg_index;
    logic [sgql_pkg::CFG_W-1:0]    i_cfg_data;

    spectral_grid_quadrilinear_lookup_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copy of the configuration and of the sample store.
    logic [sgql_pkg::SZ_W-1:0]     cells_x, cells_y, cells_z, chan_cnt;
    logic [1:0]                    wrap_sel;
    logic [sgql_pkg::LAM_W-1:0]    band_lo, band_hi;
    logic [sgql_pkg::SCALE_W-1:0]  lam_scale;
    logic [sgql_pkg::SAMPLE_W-1:0] sample_store [0:65535];
    bit                            stored [0:65535];
    logic [sgql_pkg::ADDR_W-1:0]   tap_addr [0:15];
    bit                            tap_used;

    sgql_pkg::t_out_item expected_lookups [$];
    int                  error_count;
    int                  items_sent;
    int                  tx_idle_pct;
    int                  rx_idle_pct;
    bit                  rx_hold;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #40ms;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic sgql_pkg::t_in_item rand_item();
        sgql_pkg::t_in_item r;
        r.cmd           = 1'($urandom);
        r.write_address = 16'($urandom);
        r.write_sample  = 24'($urandom);
        r.pos_x         = 24'($urandom);
        r.pos_y         = 24'($urandom);
        r.pos_z         = 24'($urandom);
        r.wavelength    = 20'($urandom);
        return r;
    endfunction

    function automatic longint eff_cells(input logic [sgql_pkg::SZ_W-1:0] v,
                                         input longint mx);
        longint r;
        r = longint'(v);
        if (r == 0) begin
            r = 1;
        end else if (r > mx) begin
            r = mx;
        end
        return r;
    endfunction

    function automatic longint wrap_axis(input longint v, input longint n);
        longint d;
        longint m;
        bit     even;
        if (wrap_sel != sgql_pkg::WRAP_REPEAT && wrap_sel != sgql_pkg::WRAP_MIRROR) begin
            if (v < 0) return 0;
            if (v > n - 1) return n - 1;
            return v;
        end
        d = v / n;
        m = v - d * n;
        if (m < 0) m += n;
        if (wrap_sel == sgql_pkg::WRAP_MIRROR) begin
            even = ((d % 2) == 0);
            if (even == (v < 0)) m = n - 1 - m;
        end
        return m;
    endfunction

    // Computes the interpolated spectrum value and leaves the sixteen store
    // addresses it reads in tap_addr; tap_used is low for out-of-band queries.
    function automatic sgql_pkg::t_out_item predict_lookup(input sgql_pkg::t_in_item q);
        sgql_pkg::t_out_item          r;
        longint                       n [0:2];
        longint                       p [0:2];
        longint                       t, nch, wi, c, x, y, z;
        longint                       lo [0:2];
        longint                       hi [0:2];
        longint                       ci [0:1];
        logic [sgql_pkg::WGT_W-1:0]   w [0:3];
        longint unsigned              s;
        longint unsigned              v [0:15];
        longint unsigned              a;
        int                           cnt;
        r = '0;
        tap_used = 1'b0;
        if (q.wavelength < band_lo || q.wavelength > band_hi) begin
            r.out_of_band = 1'b1;
            return r;
        end
        tap_used = 1'b1;
        n[0] = eff_cells(cells_x, sgql_pkg::MAX_X);
        n[1] = eff_cells(cells_y, sgql_pkg::MAX_Y);
        n[2] = eff_cells(cells_z, sgql_pkg::MAX_Z);
        nch = eff_cells(chan_cnt, sgql_pkg::MAX_CHANNELS);
        p[0] = longint'($signed(q.pos_x));
        p[1] = longint'($signed(q.pos_y));
        p[2] = longint'($signed(q.pos_z));
        for (int k = 0; k < 3; k++) begin
            t = p[k] * n[k] - 32768;
            w[k] = t[15:0];
            lo[k] = wrap_axis(t >>> 16, n[k]);
            hi[k] = wrap_axis((t >>> 16) + 1, n[k]);
        end
        s = longint'(q.wavelength - band_lo) * longint'(lam_scale);
        wi = longint'(s >> 32);
        w[3] = s[31:16];
        for (int k = 0; k < 2; k++) begin
            c = wi + k;
            ci[k] = (c > nch - 1) ? nch - 1 : c;
        end
        for (int k = 0; k < 16; k++) begin
            x = k[0] ? hi[0] : lo[0];
            y = k[1] ? hi[1] : lo[1];
            z = k[2] ? hi[2] : lo[2];
            c = ci[k[3]];
            a = longint'(((z * n[1] + y) * n[0] + x) * nch + c);
            tap_addr[k] = a[15:0];
            v[k] = longint'(sample_store[a[15:0]]);
        end
        cnt = 16;
        for (int ax = 0; ax < 4; ax++) begin
            cnt = cnt / 2;
            for (int k = 0; k < cnt; k++) begin
                v[k] = ((65536 - longint'(w[ax])) * v[2*k] + longint'(w[ax]) * v[2*k+1]) >> 16;
            end
        end
        r.sample_out = v[0][sgql_pkg::SAMPLE_W-1:0];
        return r;
    endfunction

    task automatic send_item(input sgql_pkg::t_in_item item);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid = 1'b0;
            i_in = rand_item();
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in = item;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        if (item.cmd == sgql_pkg::CMD_WRITE) begin
            sample_store[item.write_address] = item.write_sample;
            stored[item.write_address] = 1'b1;
        end else begin
            expected_lookups.push_back(predict_lookup(item));
        end
        items_sent++;
    endtask

    task automatic store_sample(input logic [sgql_pkg::ADDR_W-1:0] addr,
                                input logic [sgql_pkg::SAMPLE_W-1:0] val);
        sgql_pkg::t_in_item item;
        item = rand_item();
        item.cmd = sgql_pkg::CMD_WRITE;
        item.write_address = addr;
        item.write_sample = val;
        send_item(item);
    endtask

    // Fills every not yet written store entry the query will touch before sending it.
    task automatic query_point(input logic [sgql_pkg::POS_W-1:0] px,
                               input logic [sgql_pkg::POS_W-1:0] py,
                               input logic [sgql_pkg::POS_W-1:0] pz,
                               input logic [sgql_pkg::LAM_W-1:0] lam);
        sgql_pkg::t_in_item  item;
        sgql_pkg::t_out_item dummy;
        item = rand_item();
        item.cmd = sgql_pkg::CMD_QUERY;
        item.pos_x = px;
        item.pos_y = py;
        item.pos_z = pz;
        item.wavelength = lam;
        dummy = predict_lookup(item);
        if (tap_used) begin
            for (int k = 0; k < 16; k++) begin
                if (!stored[tap_addr[k]]) store_sample(tap_addr[k], 24'($urandom));
            end
        end
        send_item(item);
    endtask

    task automatic write_reg(input sgql_pkg::t_cfg_idx idx,
                             input logic [sgql_pkg::CFG_W-1:0] d);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait (expected_lookups.size() == 0);
        repeat (10) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = d;
        case (idx)
            sgql_pkg::CFG_SIZE_X:         cells_x = d[sgql_pkg::SZ_W-1:0];
            sgql_pkg::CFG_SIZE_Y:         cells_y = d[sgql_pkg::SZ_W-1:0];
            sgql_pkg::CFG_SIZE_Z:         cells_z = d[sgql_pkg::SZ_W-1:0];
            sgql_pkg::CFG_CHANNEL_COUNT:  chan_cnt = d[sgql_pkg::SZ_W-1:0];
            sgql_pkg::CFG_WRAP_MODE:      wrap_sel = d[1:0];
            sgql_pkg::CFG_BAND_LOW:       band_lo = d[sgql_pkg::LAM_W-1:0];
            sgql_pkg::CFG_BAND_HIGH:      band_hi = d[sgql_pkg::LAM_W-1:0];
            sgql_pkg::CFG_SPECTRAL_SCALE: lam_scale = d;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic [sgql_pkg::SZ_W-1:0] pick_cells();
        int r;
        r = $urandom_range(99);
        if (r < 8) return 5'd0;
        if (r < 14) return 5'd16;
        if (r < 18) return 5'($urandom_range(17, 31));
        return 5'($urandom_range(1, 5));
    endfunction

    task automatic pick_config();
        logic [sgql_pkg::LAM_W-1:0] lo, hi;
        longint unsigned            sc;
        longint                     nch;
        logic [sgql_pkg::SZ_W-1:0]  ch;
        write_reg(sgql_pkg::CFG_SIZE_X, pick_cells());
        write_reg(sgql_pkg::CFG_SIZE_Y, pick_cells());
        write_reg(sgql_pkg::CFG_SIZE_Z, pick_cells());
        ch = pick_cells();
        write_reg(sgql_pkg::CFG_CHANNEL_COUNT, ch);
        write_reg(sgql_pkg::CFG_WRAP_MODE, $urandom_range(3));
        lo = 20'($urandom_range(0, 200000));
        hi = lo + 20'($urandom_range(0, 400000));
        if ($urandom_range(9) == 0) hi = lo - 20'($urandom_range(1, 1000));
        if ($urandom_range(9) == 0) begin
            lo = '0;
            hi = '1;
        end
        write_reg(sgql_pkg::CFG_BAND_LOW, lo);
        write_reg(sgql_pkg::CFG_BAND_HIGH, hi);
        nch = eff_cells(ch, sgql_pkg::MAX_CHANNELS);
        if (hi > lo) begin
            sc = ((nch - 1) << 32) / longint'(hi - lo);
            if (sc > 64'hFFFF_FFFF) sc = 64'hFFFF_FFFF;
        end else begin
            sc = longint'($urandom);
        end
        case ($urandom_range(7))
            0: sc = 0;
            1: sc = 64'hFFFF_FFFF;
            2: sc = longint'($urandom);
            default: ;
        endcase
        write_reg(sgql_pkg::CFG_SPECTRAL_SCALE, sc[31:0]);
    endtask

    task automatic random_query();
        logic [sgql_pkg::POS_W-1:0] p [0:2];
        logic [sgql_pkg::LAM_W-1:0] lam;
        for (int k = 0; k < 3; k++) begin
            if ($urandom_range(9) == 0) p[k] = 24'($urandom);
            else p[k] = 24'($signed($urandom_range(0, 32'h28000)) - 32'sh8000);
        end
        if (band_lo <= band_hi && $urandom_range(9) < 8) begin
            lam = band_lo + 20'($urandom_range(0, band_hi - band_lo));
        end else begin
            lam = 20'($urandom);
        end
        query_point(p[0], p[1], p[2], lam);
    endtask

    task automatic test_directed();
        write_reg(sgql_pkg::CFG_SIZE_X, 1);
        write_reg(sgql_pkg::CFG_SIZE_Y, 1);
        write_reg(sgql_pkg::CFG_SIZE_Z, 1);
        write_reg(sgql_pkg::CFG_CHANNEL_COUNT, 2);
        write_reg(sgql_pkg::CFG_WRAP_MODE, sgql_pkg::WRAP_CLAMP);
        write_reg(sgql_pkg::CFG_BAND_LOW, 20'd1000);
        write_reg(sgql_pkg::CFG_BAND_HIGH, 20'd3000);
        write_reg(sgql_pkg::CFG_SPECTRAL_SCALE, 32'd2147483);
        store_sample(16'd0, 24'hFFFFFF);
        store_sample(16'd1, 24'h000000);
        store_sample(16'hFFFF, 24'hFFFFFF);
        query_point(24'h7FFFFF, 24'h800000, 24'h008000, 20'd1000);
        query_point(24'h800000, 24'h7FFFFF, 24'h000000, 20'd3000);
        query_point(24'h008000, 24'h008000, 24'h008000, 20'd2000);
        query_point(24'h000000, 24'h000000, 24'h000000, 20'd999);
        query_point(24'h000000, 24'h000000, 24'h000000, 20'd3001);
        query_point(24'h000000, 24'h000000, 24'h000000, 20'hFFFFF);
        query_point(24'h000000, 24'h000000, 24'h000000, 20'd0);
        write_reg(sgql_pkg::CFG_BAND_LOW, 20'd5000);
        query_point(24'h008000, 24'h008000, 24'h008000, 20'd4000);
        write_reg(sgql_pkg::CFG_BAND_LOW, 20'd0);
        write_reg(sgql_pkg::CFG_BAND_HIGH, 20'hFFFFF);
        write_reg(sgql_pkg::CFG_SPECTRAL_SCALE, 32'hFFFFFFFF);
        query_point(24'h004000, 24'h00C000, 24'h000000, 20'hFFFFF);
        write_reg(sgql_pkg::CFG_WRAP_MODE, sgql_pkg::WRAP_REPEAT);
        write_reg(sgql_pkg::CFG_SIZE_X, 2);
        query_point(24'hFF0000, 24'h000000, 24'h000000, 20'd0);
        write_reg(sgql_pkg::CFG_WRAP_MODE, sgql_pkg::WRAP_MIRROR);
        query_point(24'hFE8000, 24'h018000, 24'h000000, 20'd0);
    endtask

    task automatic test_random(input int tx_pct, input int rx_pct, input int target);
        int goal;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        goal = items_sent + target;
        while (items_sent < goal) begin
            pick_config();
            repeat ($urandom_range(10, 40)) begin
                if (items_sent < goal) begin
                    if ($urandom_range(9) < 2) store_sample(16'($urandom), 24'($urandom));
                    else random_query();
                end
            end
        end
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        pick_config();
        fork
            begin
                rx_hold = 1'b1;
                repeat (3000) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            begin
                repeat (8) begin
                    random_query();
                    store_sample(16'($urandom), 24'($urandom));
                end
            end
        join
    endtask

    always @(negedge i_clk) begin
        i_out_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        sgql_pkg::t_out_item exp_item;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_lookups.size() == 0) begin
                report_mismatch("result transaction with no query outstanding");
            end else begin
                exp_item = expected_lookups.pop_front();
                if (o_out.sample_out !== exp_item.sample_out)
                    report_mismatch($sformatf("sample_out %h, expected %h",
                                              o_out.sample_out, exp_item.sample_out));
                if (o_out.out_of_band !== exp_item.out_of_band)
                    report_mismatch($sformatf("out_of_band %b, expected %b",
                                              o_out.out_of_band, exp_item.out_of_band));
            end
        end
    end

    initial begin
        error_count = 0;
        items_sent = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        cells_x = 5'd16;
        cells_y = 5'd16;
        cells_z = 5'd16;
        chan_cnt = 5'd16;
        wrap_sel = sgql_pkg::WRAP_CLAMP;
        band_lo = '0;
        band_hi = '1;
        lam_scale = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(12, 70, 600);
        test_random(70, 12, 600);
        test_random(0, 0, 600);
        test_backpressure();

        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait (expected_lookups.size() == 0);
        repeat (200) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
